[rtl/core/erl_pkg.sv]
// Package for the elementwise ReLU layer: item codes, sequencer states,
// fixed-point widths and the 32-bit saturation helper.
// No dependencies.
`default_nettype none

package erl_pkg;

	// fraction bits of the fixed-point format (Q16.16)
	localparam int FRAC_BITS = 16;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 8;
	localparam int LR_W   = 31;
	localparam logic [LR_W-1:0] LR_RESET = 31'd655;

	// shared multiplier operand and product widths
	localparam int OPND_W = DATA_W + 1;
	localparam int PROD_W = 2 * OPND_W;
	// |g*x| fits in 63 bits, times a 31-bit rate
	localparam int MAG_W  = 63;
	localparam int ACC_W  = MAG_W + LR_W;
	localparam int QSHIFT = 2 * FRAC_BITS;
	// update term magnitude is capped at 2^33
	localparam int Q_W    = 34;
	localparam logic [Q_W-1:0] Q_CAP = 34'h2_0000_0000;
	localparam int TERM_W = Q_W + 2;

	localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(64'sd2147483647);
	localparam logic signed [PROD_W-1:0] S32_MIN = -S32_MAX - 1;

	typedef enum logic [1:0] {
		FUNC_FWD   = 2'd0,
		FUNC_BWD   = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_FMUL,
		ST_FRES,
		ST_BMUL_GW,
		ST_BMUL_GX,
		ST_BMAG,
		ST_BMUL_LO,
		ST_BMUL_HI,
		ST_BACC,
		ST_BQUOT,
		ST_BUPD,
		ST_DONE
	} state_t;

	// {clipped, value} of v saturated to the signed 32-bit range
	function automatic logic [DATA_W:0] clip32(input logic signed [PROD_W-1:0] v);
		logic [DATA_W:0] r;
		if (v > S32_MAX) begin
			r = {1'b1, 32'h7fff_ffff};
		end else if (v < S32_MIN) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[DATA_W-1:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/core/erl_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module erl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/core/elementwise_relu_layer_sgd.sv]
// Sequencer steps: forward READ, FMUL, FRES, DONE; backward READ, BMUL_GW, BMUL_GX, BMAG,
// BMUL_LO, BMUL_HI, BACC, BQUOT, BUPD, DONE; weight write/read or an out-of-range index
// just READ, DONE. One request in flight at a time. The shared 33x33 multiplier is used once by
// forward and four times by backward (plus magnitude, accumulate, quotient and update steps);
// a finished result waits in the output register while the next is taken. Reset (arst_n low,
// async) clears sequencer, output valid, step size (655) and sample valid bits; weights are
// undefined until written. Depends on erl_pkg and erl_ram.
`default_nettype none

module elementwise_relu_layer_sgd
	import erl_pkg::*;
#(
	parameter int ELEMENT_COUNT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input request
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,   // [7:0] index, [39:8] value
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
	// result
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [39:0] m_axis_tdata,   // [7:0] out_index, [39:8] out_value
	output logic             m_axis_tuser,   // [0] saturated
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int DEPTH = (ELEMENT_COUNT > 256) ? 256 : ELEMENT_COUNT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t state_q, state_d;

	logic [LR_W-1:0]          lr_q;
	func_t                    func_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     idx_ok_q;
	logic signed [DATA_W-1:0] value_q;
	logic signed [DATA_W-1:0] w_q;
	logic signed [DATA_W-1:0] x_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     neg_q;
	logic [ACC_W-1:0]         acc_q;
	logic signed [TERM_W-1:0] term_q;
	logic [DATA_W-1:0]        res_q;
	logic                     sat_q;
	logic                     out_valid_q;
	logic [39:0]              out_data_q;
	logic                     out_sat_q;
	logic [DEPTH-1:0]         sample_vld_q;
	logic                     vld_rd_q;

	logic                     accept;
	logic                     in_idx_ok;
	logic [AW-1:0]            raddr;
	logic [AW-1:0]            addr_q;
	logic [DATA_W-1:0]        w_rd;
	logic [DATA_W:0]          s_rd;
	logic                     flag_rd;
	logic signed [DATA_W-1:0] x_rd;

	logic                     w_we;
	logic [DATA_W-1:0]        w_wdata;
	logic                     s_we;
	logic signed [OPND_W-1:0] mul_a, mul_b;
	logic                     out_load;

	logic signed [PROD_W-1:0] res_shift;
	logic [DATA_W:0]          res_clip;
	logic                     prod_pos;
	logic [ACC_W-1:0]         q_full;
	logic                     q_rem;
	logic                     q_capped;
	logic [TERM_W-1:0]        t_mag;
	logic signed [TERM_W-1:0] nw_wide;
	logic [DATA_W:0]          nw_clip;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {1'b0, lr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= LR_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			lr_q <= pwdata[LR_W-1:0];
		end
	end

	// ---------------------------------------------------------------- storage
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign in_idx_ok = 32'(s_axis_tdata[IDX_W-1:0]) < ELEMENT_COUNT;
	assign raddr     = s_axis_tdata[AW-1:0];
	assign addr_q    = idx_q[AW-1:0];

	erl_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (addr_q),
		.wdata (w_wdata),
		.raddr (raddr),
		.rdata (w_rd)
	);

	// each entry holds {active flag, sample}
	erl_ram #(.WIDTH(DATA_W + 1), .DEPTH(DEPTH)) u_sample_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (addr_q),
		.wdata ({prod_pos, value_q}),
		.raddr (raddr),
		.rdata (s_rd)
	);

	// an entry never written since reset reads as zero
	assign flag_rd = vld_rd_q && s_rd[DATA_W];
	assign x_rd    = vld_rd_q ? s_rd[DATA_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_vld_q <= '0;
		end else if (s_we) begin
			sample_vld_q[addr_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		vld_rd_q <= sample_vld_q[raddr];
	end

	// ---------------------------------------------------------------- arithmetic
	assign res_shift = prod_q >>> FRAC_BITS;
	assign res_clip  = clip32(res_shift);
	assign prod_pos  = !prod_q[PROD_W-1] && (prod_q != '0);

	assign q_full   = acc_q >> QSHIFT;
	assign q_rem    = |(acc_q & ((ACC_W'(1) << QSHIFT) - ACC_W'(1)));
	assign q_capped = q_full > ACC_W'(Q_CAP);
	// floor rounding: bump the magnitude only when the term is negative
	assign t_mag    = q_capped ? TERM_W'(Q_CAP)
	                           : TERM_W'(q_full[Q_W-1:0]) + TERM_W'(neg_q && q_rem);

	assign nw_wide = {{(TERM_W - DATA_W){w_q[DATA_W-1]}}, w_q} - term_q;
	assign nw_clip = clip32(PROD_W'(nw_wide));

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_READ;
			end
			ST_READ: begin
				if (!idx_ok_q) begin
					state_d = ST_DONE;
				end else begin
					unique case (func_q)
						FUNC_FWD:   state_d = ST_FMUL;
						FUNC_BWD:   state_d = ST_BMUL_GW;
						FUNC_WRITE: state_d = ST_DONE;
						FUNC_READ:  state_d = ST_DONE;
					endcase
				end
			end
			ST_FMUL:    state_d = ST_FRES;
			ST_FRES:    state_d = ST_DONE;
			ST_BMUL_GW: state_d = ST_BMUL_GX;
			ST_BMUL_GX: state_d = ST_BMAG;
			ST_BMAG:    state_d = ST_BMUL_LO;
			ST_BMUL_LO: state_d = ST_BMUL_HI;
			ST_BMUL_HI: state_d = ST_BACC;
			ST_BACC:    state_d = ST_BQUOT;
			ST_BQUOT:   state_d = ST_BUPD;
			ST_BUPD:    state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- outputs
	always_comb begin
		s_axis_tready = 1'b0;
		w_we          = 1'b0;
		w_wdata       = value_q;
		s_we          = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_READ: w_we = idx_ok_q && func_q == FUNC_WRITE;
			ST_FMUL: begin
				mul_a = OPND_W'(value_q);
				mul_b = OPND_W'(w_q);
			end
			ST_FRES: s_we = 1'b1;
			ST_BMUL_GW: begin
				mul_a = OPND_W'(value_q);
				mul_b = OPND_W'(w_q);
			end
			ST_BMUL_GX: begin
				mul_a = OPND_W'(value_q);
				mul_b = OPND_W'(x_q);
			end
			ST_BMUL_LO: begin
				mul_a = {1'b0, mag_q[31:0]};
				mul_b = {2'b00, lr_q};
			end
			ST_BMUL_HI: begin
				mul_a = {2'b00, mag_q[MAG_W-1:32]};
				mul_b = {2'b00, lr_q};
			end
			ST_BUPD: begin
				w_we    = 1'b1;
				w_wdata = nw_clip[DATA_W-1:0];
			end
			ST_DONE: out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- control regs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- datapath regs
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			func_q   <= func_t'(s_axis_tuser);
			idx_q    <= s_axis_tdata[IDX_W-1:0];
			idx_ok_q <= in_idx_ok;
			value_q  <= s_axis_tdata[39:8];
		end
		unique case (state_q)
			ST_READ: begin
				w_q   <= w_rd;
				x_q   <= x_rd;
				sat_q <= 1'b0;
				// drop the gradient of an inactive element
				if (func_q == FUNC_BWD && !flag_rd) value_q <= '0;
				if (!idx_ok_q) begin
					res_q <= '0;
				end else if (func_q == FUNC_WRITE) begin
					res_q <= value_q;
				end else begin
					res_q <= (func_q == FUNC_READ) ? w_rd : '0;
				end
			end
			ST_FRES: begin
				res_q <= prod_pos ? res_clip[DATA_W-1:0] : '0;
				sat_q <= prod_pos && res_clip[DATA_W];
			end
			ST_BMUL_GX: begin
				res_q <= res_clip[DATA_W-1:0];
				sat_q <= res_clip[DATA_W];
			end
			ST_BMAG: begin
				neg_q <= prod_q[PROD_W-1];
				mag_q <= prod_q[PROD_W-1] ? MAG_W'(-prod_q) : prod_q[MAG_W-1:0];
			end
			ST_BMUL_HI: acc_q <= ACC_W'(prod_q[MAG_W-1:0]);
			ST_BACC:    acc_q <= acc_q + (ACC_W'(prod_q[61:0]) << 32);
			ST_BQUOT:   term_q <= neg_q ? -$signed(t_mag) : $signed(t_mag);
			ST_BUPD:    sat_q <= sat_q | nw_clip[DATA_W];
			default: ;
		endcase
		if (out_load) begin
			out_data_q <= {res_q, idx_q};
			out_sat_q  <= sat_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_sat_q;

	// ---------------------------------------------------------------- checks
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_READ)
		else $error("accepted request did not start a RAM read");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_DONE)
		else $error("result appeared outside the completion step");

	a_no_sat_on_access: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (func_q == FUNC_WRITE || func_q == FUNC_READ)) |-> !sat_q)
		else $error("weight write or read flagged saturation");

	a_weight_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		w_we |-> idx_ok_q)
		else $error("weight written for an index beyond the element count");

	a_sample_marked: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FRES |=> sample_vld_q[addr_q])
		else $error("cached sample stored without its valid bit");

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for elementwise_relu_layer_sgd: forward, backward, weight
// write/read and step-size changes over the request/result streams and the APB port.
// Depends on erl_pkg (func_t, widths) and the RTL of the layer.
`timescale 1ns / 100ps

module tb_top;
	import erl_pkg::*;

	localparam int ELEMENTS       = 256;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_PRINTS     = 30;
	localparam logic [2:0] ADDR_STEP_SIZE = 3'd0;
	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -64'sd2147483648;
	localparam logic [127:0] UPDATE_CAP = 128'd1 << 33;

	typedef struct packed {
		logic [7:0]  index;
		logic [31:0] value;
		logic        saturated;
	} layer_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// predictor state
	logic signed [31:0] weight_mem [ELEMENTS];
	logic signed [31:0] sample_mem [ELEMENTS];
	bit active_mem [ELEMENTS];
	bit weight_loaded [ELEMENTS];
	logic [30:0] learn_rate = 31'd655;

	layer_result_t pending_results [$];
	int mismatches = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int rate_writes = 0;
	int idle_cycles = 0;
	bit steady_flow = 1'b0;
	bit hold_output = 1'b0;

	always #1 clk = ~clk;

	elementwise_relu_layer_sgd u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata(s_tdata),     // [7:0] index, [39:8] value
		.s_axis_tuser(s_tuser),     // [1:0] func
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_tdata),     // [7:0] out_index, [39:8] out_value
		.m_axis_tuser(m_tuser),     // [0] saturated
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	function automatic bit fits32(input longint val);
		return (val <= S32_HI) && (val >= S32_LO);
	endfunction

	function automatic logic [31:0] clamp32(input longint val);
		if (val > S32_HI) begin
			return 32'h7fff_ffff;
		end else if (val < S32_LO) begin
			return 32'h8000_0000;
		end
		return val[31:0];
	endfunction

	// Apply one request to the predictor state and return the result it causes.
	function automatic layer_result_t layer_response(input func_t op, input logic [7:0] idx,
			input logic signed [31:0] v);
		layer_result_t r;
		longint w, p, g, x, gw, gx, term, nw;
		logic [63:0] mag;
		logic [127:0] full, q;
		bit rem, clipped;
		r.index = idx;
		r.value = '0;
		clipped = 1'b0;
		w = weight_mem[idx];
		case (op)
			FUNC_FWD: begin
				p = longint'(v) * w;
				sample_mem[idx] = v;
				active_mem[idx] = (p > 0);
				if (p > 0) begin
					p = p >>> FRAC_BITS;
					clipped = !fits32(p);
					r.value = clamp32(p);
				end
			end
			FUNC_BWD: begin
				g = active_mem[idx] ? longint'(v) : 64'sd0;
				x = sample_mem[idx];
				gw = (g * w) >>> FRAC_BITS;
				clipped = !fits32(gw);
				r.value = clamp32(gw);
				// lr*g*x scaled by 2*FRAC_BITS, floor rounding, magnitude capped at 2^33
				gx = g * x;
				mag = (gx < 0) ? -gx : gx;
				full = {64'b0, mag} * {97'b0, learn_rate};
				q = full >> (2 * FRAC_BITS);
				rem = |full[2*FRAC_BITS-1:0];
				if (q > UPDATE_CAP) begin
					q = UPDATE_CAP;
					rem = 1'b0;
				end
				term = longint'(q[63:0]);
				if (gx < 0) begin
					term = -(term + (rem ? 64'sd1 : 64'sd0));
				end
				nw = w - term;
				if (!fits32(nw)) begin
					clipped = 1'b1;
				end
				weight_mem[idx] = clamp32(nw);
			end
			FUNC_WRITE: begin
				weight_mem[idx] = v;
				weight_loaded[idx] = 1'b1;
				r.value = v;
			end
			default: begin
				r.value = weight_mem[idx];
			end
		endcase
		r.saturated = clipped;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= MAX_PRINTS) begin
			$display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
		end
	endtask

	task automatic send_request(input func_t op, input logic [7:0] idx, input logic [31:0] value);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {value, idx};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(layer_response(op, idx, value));
		requests_sent++;
	endtask

	// Drop valid and wait until every result has come back.
	task automatic drain_layer();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_rate(input logic [30:0] rate);
		logic [31:0] readback;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_STEP_SIZE;
		pwdata <= {1'($urandom_range(0, 1)), rate};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		learn_rate = rate;
		rate_writes++;
		// read it back
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== {1'b0, learn_rate}) begin
			report_mismatch("step size readback", {1'b0, learn_rate}, readback);
		end
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 6))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'h0000_0001;
					4: return 32'hffff_ffff;
					5: return 32'h0001_0000;
					default: return 32'hffff_0000;
				endcase
			end
			1, 2: return $urandom;
			default: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	function automatic logic [31:0] rand_weight();
		if ($urandom_range(0, 3) == 0) begin
			return rand_value();
		end
		return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
	endfunction

	// Mostly forward/backward pairs on a loaded weight, with writes, reads and stray backwards.
	task automatic run_traffic(input int count);
		int first;
		logic [7:0] idx;
		first = requests_sent;
		while (requests_sent - first < count) begin
			if ($urandom_range(0, 39) == 0) begin
				steady_flow = !steady_flow;
			end
			idx = $urandom_range(0, ELEMENTS - 1);
			if (!weight_loaded[idx]) begin
				send_request(FUNC_WRITE, idx, rand_weight());
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					send_request(FUNC_FWD, idx, rand_value());
					send_request(FUNC_BWD, idx, rand_value());
					if ($urandom_range(0, 3) == 0) begin
						send_request(FUNC_READ, idx, $urandom);
					end
				end
				6: send_request(FUNC_WRITE, idx, rand_weight());
				7: send_request(FUNC_READ, idx, $urandom);
				8: send_request(FUNC_BWD, idx, rand_value());
				default: send_request(FUNC_FWD, idx, rand_value());
			endcase
		end
	endtask

	task automatic test_directed();
		send_request(FUNC_WRITE, 8'd0, 32'h7fff_ffff);
		send_request(FUNC_WRITE, 8'd255, 32'h8000_0000);
		send_request(FUNC_WRITE, 8'd1, 32'h0001_0000);
		send_request(FUNC_WRITE, 8'd2, 32'hffff_0000);
		send_request(FUNC_WRITE, 8'd3, 32'h0000_0000);
		send_request(FUNC_READ, 8'd0, 32'h0);
		send_request(FUNC_READ, 8'd255, 32'hffff_ffff);
		// flag still clear from reset: inactive backward
		send_request(FUNC_BWD, 8'd1, 32'h0001_0000);
		send_request(FUNC_FWD, 8'd0, 32'h7fff_ffff);
		send_request(FUNC_FWD, 8'd255, 32'h8000_0000);
		send_request(FUNC_FWD, 8'd1, 32'h0003_0000);
		send_request(FUNC_FWD, 8'd2, 32'h0003_0000);
		send_request(FUNC_FWD, 8'd3, 32'h0001_2345);
		send_request(FUNC_BWD, 8'd0, 32'h7fff_ffff);
		send_request(FUNC_BWD, 8'd255, 32'h8000_0000);
		send_request(FUNC_BWD, 8'd1, 32'h0000_8000);
		send_request(FUNC_BWD, 8'd2, 32'h0001_0000);
		send_request(FUNC_READ, 8'd0, 32'h0);
		send_request(FUNC_READ, 8'd255, 32'h0);
		send_request(FUNC_READ, 8'd1, 32'h0);
		send_request(FUNC_FWD, 8'd1, 32'hffff_ffff);
		send_request(FUNC_FWD, 8'd3, 32'h8000_0000);
		send_request(FUNC_WRITE, 8'd128, 32'haaaa_aaaa);
		send_request(FUNC_WRITE, 8'd127, 32'h5555_5555);
		send_request(FUNC_READ, 8'd128, 32'h0);
	endtask

	task automatic test_rate_sweep();
		logic [30:0] rates [6];
		rates = '{31'd0, 31'h7fff_ffff, 31'd65536, 31'd1, 31'($urandom), 31'd655};
		foreach (rates[i]) begin
			drain_layer();
			write_rate(rates[i]);
			run_traffic(160);
		end
	endtask

	task automatic test_random_rate();
		drain_layer();
		write_rate(31'($urandom_range(0, 1 << 20)));
		run_traffic(450);
	endtask

	// Hold the result side off while requests keep coming, so the input backs up.
	task automatic test_output_stall();
		steady_flow = 1'b1;
		hold_output = 1'b1;
		run_traffic(40);
		steady_flow = 1'b0;
	endtask

	always @(posedge clk) begin : result_check
		layer_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 32'h0, m_tdata[39:8]);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[7:0] !== want.index) begin
					report_mismatch("out_index", 32'(want.index), 32'(m_tdata[7:0]));
				end
				if (m_tdata[39:8] !== want.value) begin
					report_mismatch("out_value", want.value, m_tdata[39:8]);
				end
				if (m_tuser !== want.saturated) begin
					report_mismatch("saturated", 32'(want.saturated), 32'(m_tuser));
				end
			end
		end
	end

	initial begin : result_sink
		int stall;
		forever begin
			@(negedge clk);
			stall = steady_flow ? 0 : $urandom_range(0, 7);
			if (hold_output) begin
				stall = LONG_HOLD;
				hold_output = 1'b0;
			end
			repeat (stall) begin
				m_tready <= 1'b0;
				@(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request or result moved for %0d cycles", idle_cycles);
			$display("[elementwise_relu_layer_sgd] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		foreach (active_mem[i]) begin
			active_mem[i] = 1'b0;
			sample_mem[i] = '0;
			weight_mem[i] = '0;
			weight_loaded[i] = 1'b0;
		end
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_rate_sweep();
		test_random_rate();
		test_output_stall();

		drain_layer();
		repeat (20) @(posedge clk);
		$display("covered %0d requests and %0d results over %0d step-size settings,",
			requests_sent, results_checked, rate_writes + 1);
		$display("including zero and full-scale rates and a %0d-cycle result stall",
			LONG_HOLD);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("[elementwise_relu_layer_sgd] OK");
		end else begin
			$display("[elementwise_relu_layer_sgd] ERROR");
		end
		$finish;
	end

endmodule
